@@ sv/mbp_pkg.sv @@
package mbp_pkg;

	localparam int WORD_BITS      = 16;
	localparam int MAX_FIELD_BITS = 64;
	localparam int MAX_WORDS      = 4;
	localparam int LEN_W          = 7;
	localparam int CNT_W          = 4;
	localparam int NW_W           = 3;
	localparam int IDX_W          = 2;
	localparam int BUF_BITS       = WORD_BITS + MAX_FIELD_BITS;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_FLUSH  = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef struct packed {
		logic [MAX_WORDS-1:0][WORD_BITS-1:0] words;
		logic [NW_W-1:0]                     nwords;
	} burst_t;

endpackage

@@ sv/msb_first_bit_packer.sv @@
// MSB-first bit packer, 16-bit output words.
// Input channel (in_valid/in_stall): op selects append, flush or clear.
//   Append takes the low field_len bits of field_value (lengths above 64
//   count as 64) and shifts them in behind the pending bits, earliest bit
//   toward bit 15 of the word. Flush emits the pending bits padded with
//   zeros, if any, and clears them. Clear drops the pending bits. Op 3 and
//   empty appends give nothing.
// Output channel (out_valid/out_stall): one packed_word per beat;
//   last_word marks the final word that one input item caused.
// The front end accepts one item per cycle while its two-entry queue has
//   room; it stalls only when the queue is full.
// Flow: an accepted item that yields words is written into the queue, and
//   its first word then moves into the output register, which drives
//   out_valid. The output side sends one word per cycle while out_stall is
//   low; an item yields 0 to 4 words, so sustained rate is set by that count.
// Reset clears the pending bits, empties the queue and drops out_valid.
// While out_stall is high the current beat holds; the queue then fills and
//   in_stall rises.
module msb_first_bit_packer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    op,
	input  logic [63:0]                   field_value,
	input  logic [mbp_pkg::LEN_W-1:0]     field_len,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mbp_pkg::WORD_BITS-1:0] packed_word,
	output logic                          last_word
);

	logic            push;
	mbp_pkg::burst_t push_burst;
	logic            q_full;
	logic            pop;
	logic            head_valid;
	mbp_pkg::burst_t head;

	mbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.field_value(field_value),
		.field_len  (field_len),
		.q_full     (q_full),
		.push       (push),
		.push_burst (push_burst)
	);

	mbp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_burst (push_burst),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	mbp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.packed_word(packed_word),
		.last_word  (last_word)
	);

endmodule

@@ sv/mbp_front.sv @@
module mbp_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        op,
	input  logic [63:0]                       field_value,
	input  logic [mbp_pkg::LEN_W-1:0]         field_len,
	input  logic                              q_full,
	output logic                              push,
	output mbp_pkg::burst_t                   push_burst
);

	logic [mbp_pkg::WORD_BITS-1:0] pend_word_q;
	logic [mbp_pkg::CNT_W-1:0]     pend_cnt_q;

	logic [mbp_pkg::LEN_W-1:0]          len_c;
	logic [mbp_pkg::MAX_FIELD_BITS-1:0] aligned_c;
	logic [mbp_pkg::BUF_BITS-1:0]       buf_c;
	logic [mbp_pkg::LEN_W-1:0]          total_c;
	logic [mbp_pkg::NW_W-1:0]           nwords_c;
	logic [mbp_pkg::WORD_BITS-1:0]      next_word_c;
	logic [mbp_pkg::CNT_W-1:0]          next_cnt_c;
	logic                               produce_c;
	logic                               accept_c;

	assign in_stall = q_full;
	assign accept_c = in_valid && !q_full;
	assign push     = accept_c && produce_c;

	always_comb begin
		len_c = (field_len > mbp_pkg::LEN_W'(mbp_pkg::MAX_FIELD_BITS))
			? mbp_pkg::LEN_W'(mbp_pkg::MAX_FIELD_BITS) : field_len;
		aligned_c = (len_c == '0) ? '0
			: field_value << (mbp_pkg::LEN_W'(mbp_pkg::MAX_FIELD_BITS) - len_c);
		buf_c = {pend_word_q, {mbp_pkg::MAX_FIELD_BITS{1'b0}}}
			| ({aligned_c, {mbp_pkg::WORD_BITS{1'b0}}} >> pend_cnt_q);
		total_c  = {{(mbp_pkg::LEN_W-mbp_pkg::CNT_W){1'b0}}, pend_cnt_q} + len_c;
		nwords_c = total_c[mbp_pkg::LEN_W-1:mbp_pkg::CNT_W];
		case (nwords_c)
			3'd0:    next_word_c = buf_c[79:64];
			3'd1:    next_word_c = buf_c[63:48];
			3'd2:    next_word_c = buf_c[47:32];
			3'd3:    next_word_c = buf_c[31:16];
			default: next_word_c = buf_c[15:0];
		endcase
		next_cnt_c = total_c[mbp_pkg::CNT_W-1:0];

		push_burst = '0;
		produce_c  = 1'b0;
		case (op)
			mbp_pkg::OP_APPEND: begin
				for (int k = 0; k < mbp_pkg::MAX_WORDS; k++) begin
					push_burst.words[k] = buf_c[mbp_pkg::BUF_BITS-1-k*mbp_pkg::WORD_BITS
						-: mbp_pkg::WORD_BITS];
				end
				push_burst.nwords = nwords_c;
				produce_c         = (nwords_c != '0);
			end
			mbp_pkg::OP_FLUSH: begin
				push_burst.words[0] = pend_word_q;
				push_burst.nwords   = mbp_pkg::NW_W'(1);
				produce_c           = (pend_cnt_q != '0);
			end
			default: begin
				produce_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_word_q <= '0;
			pend_cnt_q  <= '0;
		end else if (accept_c) begin
			case (op)
				mbp_pkg::OP_APPEND: begin
					pend_word_q <= next_word_c;
					pend_cnt_q  <= next_cnt_c;
				end
				mbp_pkg::OP_FLUSH, mbp_pkg::OP_CLEAR: begin
					pend_word_q <= '0;
					pend_cnt_q  <= '0;
				end
				default: begin
					pend_word_q <= pend_word_q;
					pend_cnt_q  <= pend_cnt_q;
				end
			endcase
		end
	end

endmodule

@@ sv/mbp_fifo.sv @@
module mbp_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mbp_pkg::burst_t push_burst,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output mbp_pkg::burst_t head
);

	mbp_pkg::burst_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_burst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ sv/mbp_back.sv @@
module mbp_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  mbp_pkg::burst_t               head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mbp_pkg::WORD_BITS-1:0] packed_word,
	output logic                          last_word
);

	mbp_pkg::burst_t               entry_q;
	logic                          busy_q;
	logic [mbp_pkg::IDX_W-1:0]     idx_q;
	logic                          valid_q;
	logic [mbp_pkg::WORD_BITS-1:0] word_q;
	logic                          last_q;

	mbp_pkg::burst_t               sel_c;
	logic [mbp_pkg::IDX_W-1:0]     sel_idx_c;
	logic                          sel_last_c;
	logic                          out_free_c;
	logic                          emit_c;

	assign out_free_c = !valid_q || !out_stall;
	assign sel_c      = busy_q ? entry_q : head;
	assign sel_idx_c  = busy_q ? idx_q : '0;
	assign sel_last_c = (({1'b0, sel_idx_c} + mbp_pkg::NW_W'(1)) == sel_c.nwords);
	assign emit_c     = out_free_c && (busy_q || head_valid);
	assign pop        = out_free_c && !busy_q && head_valid;

	assign out_valid   = valid_q;
	assign packed_word = word_q;
	assign last_word   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else if (out_free_c) begin
			valid_q <= emit_c;
			if (emit_c) begin
				busy_q <= !sel_last_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_c) begin
			word_q <= sel_c.words[sel_idx_c];
			last_q <= sel_last_c;
			idx_q  <= sel_idx_c + mbp_pkg::IDX_W'(1);
			if (!busy_q) begin
				entry_q <= head;
			end
		end
	end

endmodule

@@ sv/mbp_checker.sv @@
module mbp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic [1:0]                    op,
	input logic [63:0]                   field_value,
	input logic [mbp_pkg::LEN_W-1:0]     field_len,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [mbp_pkg::WORD_BITS-1:0] packed_word,
	input logic                          last_word
);

	logic [1:0] run_q;
	logic       seen_q;
	logic       out_beat;

	assign out_beat = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= '0;
			seen_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				seen_q <= 1'b1;
			end
			if (out_beat) begin
				run_q <= last_word ? 2'd0 : run_q + 2'd1;
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(packed_word) && $stable(last_word))
		else $error("stalled output beat changed");

	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && !last_word |-> run_q < 2'd3)
		else $error("more than four words from one item");

	a_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && !last_word |=> out_valid)
		else $error("gap inside a multi-word item");

	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seen_q)
		else $error("output word without any accepted item");

endmodule

bind msb_first_bit_packer mbp_checker u_mbp_checker (.*);
